@@ sv/utsc_pkg.sv @@
// Shared types and constants for the UTF-8 token splitter with case folding.
// Holds the result bundle passed from the decoder front end to the output back end.
// No dependencies.
package utsc_pkg;

    // Code point limits used by the decoder.
    localparam logic [20:0] MAX_CP       = 21'h10FFFF;
    localparam logic [20:0] SURR_LO      = 21'h00D800;
    localparam logic [20:0] SURR_HI      = 21'h00DFFF;
    localparam logic [20:0] MIN_CP_LEN1  = 21'h000080;
    localparam logic [20:0] MIN_CP_LEN2  = 21'h000800;
    localparam logic [20:0] MIN_CP_LEN3  = 21'h010000;

    // Case folding and token range boundaries.
    localparam logic [20:0] CP_TIMES     = 21'h0000D7;
    localparam logic [20:0] CP_DIVIDE    = 21'h0000F7;
    localparam logic [20:0] CP_GREEK_GAP = 21'h0003A2;
    localparam logic [20:0] CP_DZ_LO     = 21'h0001C4;
    localparam logic [20:0] CP_DZ_HI     = 21'h0001CC;
    localparam logic [20:0] CP_CYR_LO    = 21'h000410;
    localparam logic [20:0] CP_CYR_HI    = 21'h00042F;
    localparam logic [20:0] CP_HANGUL_LO = 21'h00AC00;
    localparam logic [20:0] CP_HANGUL_HI = 21'h00D7AF;

    // Bundle queue geometry.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    // All results caused by one input byte: an optional end marker before the
    // token bytes, up to three encoded bytes, and an optional end marker after.
    typedef struct packed {
        logic            pre_end;
        logic [1:0]      nbytes;
        logic [2:0][7:0] data;
        logic            post_end;
    } bundle_t;

    // Queue status seen by the producer and consumer sides.
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

@@ sv/utsc_front.sv @@
// Decoder front end: accepts raw bytes, decodes UTF-8, folds case and
// packs the results of each byte into one bundle. Depends on utsc_pkg.
module utsc_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_take,
    input  logic [7:0]        in_data,
    input  logic              in_end,
    output logic              push,
    output utsc_pkg::bundle_t push_data
);
    import utsc_pkg::*;

    logic [1:0]  rem_reg, rem_next;
    logic [1:0]  len_reg, len_next;
    logic [20:0] acc_reg, acc_next;
    logic        open_reg, open_next;
    bundle_t     bnd;

    // Token character ranges.
    function automatic logic is_tok(input logic [20:0] c);
        logic r;
        r = 1'b0;
        if (c < 21'h80) begin
            r = (c >= 21'h61 && c <= 21'h7A) || (c >= 21'h41 && c <= 21'h5A) ||
                (c >= 21'h30 && c <= 21'h39);
        end else if (c >= 21'hC0 && c <= 21'hFF) begin
            r = (c != CP_TIMES) && (c != CP_DIVIDE);
        end else begin
            r = (c >= 21'h0100 && c <= 21'h02FF) || (c >= 21'h0370 && c <= 21'h03FF) ||
                (c >= 21'h1F00 && c <= 21'h1FFF) || (c >= 21'h0400 && c <= 21'h04FF) ||
                (c >= 21'h0590 && c <= 21'h06FF) || (c >= 21'h0900 && c <= 21'h0DFF) ||
                (c >= 21'h3040 && c <= 21'h30FF) || (c >= 21'h3400 && c <= 21'h4DBF) ||
                (c >= 21'h4E00 && c <= 21'h9FFF) ||
                (c >= CP_HANGUL_LO && c <= CP_HANGUL_HI);
        end
        return r;
    endfunction

    // Case folding by range rules.
    function automatic logic [20:0] fold(input logic [20:0] c);
        logic [20:0] r;
        r = c;
        if (c >= 21'h41 && c <= 21'h5A) begin
            r = c + 21'h20;
        end else if (c >= 21'hC0 && c <= 21'hDE && c != CP_TIMES) begin
            r = c + 21'h20;
        end else if (c >= 21'h0100 && c <= 21'h017F && !c[0]) begin
            r = c + 21'h1;
        end else if (c >= 21'h0180 && c <= 21'h024F && !c[0] &&
                     (c < CP_DZ_LO || c > CP_DZ_HI)) begin
            r = c + 21'h1;
        end else if (c >= 21'h0391 && c <= 21'h03A9 && c != CP_GREEK_GAP) begin
            r = c + 21'h20;
        end else if (c >= CP_CYR_LO && c <= CP_CYR_HI) begin
            r = c + 21'h20;
        end
        return r;
    endfunction

    // Decode one byte against the current sequence state.
    always_comb begin
        logic        t;
        logic        do_cp;
        logic        do_lead;
        logic [20:0] c;
        logic [20:0] f;
        logic [20:0] min_cp;
        t        = open_reg;
        do_cp    = 1'b0;
        do_lead  = 1'b0;
        c        = 21'h0;
        f        = 21'h0;
        min_cp   = MIN_CP_LEN3;
        bnd      = '0;
        rem_next = rem_reg;
        len_next = len_reg;
        acc_next = acc_reg;

        case (len_reg)
            2'd1:    min_cp = MIN_CP_LEN1;
            2'd2:    min_cp = MIN_CP_LEN2;
            default: min_cp = MIN_CP_LEN3;
        endcase

        if (rem_reg != 2'd0) begin
            if (in_data[7:6] == 2'b10) begin
                acc_next = {acc_reg[14:0], in_data[5:0]};
                rem_next = rem_reg - 2'd1;
                if (rem_reg == 2'd1) begin
                    c = acc_next;
                    if (c < min_cp || (c >= SURR_LO && c <= SURR_HI) || c > MAX_CP) begin
                        bnd.pre_end = t;
                        t = 1'b0;
                    end else begin
                        do_cp = 1'b1;
                    end
                end
            end else begin
                // A broken sequence ends as a separator; the byte is a new lead.
                rem_next    = 2'd0;
                bnd.pre_end = t;
                t           = 1'b0;
                do_lead     = 1'b1;
            end
        end else begin
            do_lead = 1'b1;
        end

        // Lead byte classification.
        if (do_lead) begin
            if (!in_data[7]) begin
                c     = {13'h0, in_data};
                do_cp = 1'b1;
            end else if (in_data[7:5] == 3'b110) begin
                len_next = 2'd1;
                rem_next = 2'd1;
                acc_next = {16'h0, in_data[4:0]};
            end else if (in_data[7:4] == 4'b1110) begin
                len_next = 2'd2;
                rem_next = 2'd2;
                acc_next = {17'h0, in_data[3:0]};
            end else if (in_data[7:3] == 5'b11110) begin
                len_next = 2'd3;
                rem_next = 2'd3;
                acc_next = {18'h0, in_data[2:0]};
            end else begin
                if (t) begin
                    bnd.pre_end = 1'b1;
                end
                t = 1'b0;
            end
        end

        // Complete code point: fold and re-encode, or treat as a separator.
        if (do_cp) begin
            if (is_tok(c)) begin
                f = fold(c);
                if (f < 21'h80) begin
                    bnd.nbytes  = 2'd1;
                    bnd.data[0] = f[7:0];
                end else if (f < 21'h800) begin
                    bnd.nbytes  = 2'd2;
                    bnd.data[0] = {3'b110, f[10:6]};
                    bnd.data[1] = {2'b10, f[5:0]};
                end else begin
                    bnd.nbytes  = 2'd3;
                    bnd.data[0] = {4'b1110, f[15:12]};
                    bnd.data[1] = {2'b10, f[11:6]};
                    bnd.data[2] = {2'b10, f[5:0]};
                end
                t = 1'b1;
            end else begin
                if (t) begin
                    bnd.pre_end = 1'b1;
                end
                t = 1'b0;
            end
        end

        // End of text closes any open token and returns the decoder to idle.
        if (in_end) begin
            bnd.post_end = t;
            t            = 1'b0;
            rem_next     = 2'd0;
            len_next     = 2'd0;
            acc_next     = 21'h0;
        end

        open_next = t;
    end

    assign push_data = bnd;
    assign push      = in_take && (bnd.pre_end || (bnd.nbytes != 2'd0) || bnd.post_end);

    // Decoder state advances on every accepted transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg  <= 2'd0;
            len_reg  <= 2'd0;
            acc_reg  <= 21'h0;
            open_reg <= 1'b0;
        end else if (in_take) begin
            rem_reg  <= rem_next;
            len_reg  <= len_next;
            acc_reg  <= acc_next;
            open_reg <= open_next;
        end
    end

endmodule

@@ sv/utsc_queue.sv @@
// Short bundle queue between the decoder front end and the output back end.
// Depends on utsc_pkg.
module utsc_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  utsc_pkg::bundle_t   push_data,
    input  logic                pop,
    output utsc_pkg::bundle_t   pop_data,
    output utsc_pkg::q_status_t status
);
    import utsc_pkg::*;

    bundle_t                  mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0]   count_reg;

    assign status.full  = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_data     = mem_reg[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

@@ sv/utsc_back.sv @@
// Output back end: takes bundles from the queue and sends their results one
// transfer at a time, marking the last result of each bundle. Depends on utsc_pkg.
module utsc_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  utsc_pkg::bundle_t   pop_data,
    input  utsc_pkg::q_status_t status,
    output logic                pop,
    output logic [7:0]          m_out_byte,
    output logic                m_byte_valid,
    output logic                m_token_end,
    output logic                m_run_last,
    output logic                m_valid,
    input  logic                m_ready
);
    import utsc_pkg::*;

    logic [2:0][7:0] data_reg;
    logic            valid_reg;
    logic            pre_reg;
    logic            post_reg;
    logic [1:0]      left_reg;
    logic [1:0]      idx_reg;
    logic            xfer;
    logic            last;
    logic [7:0]      sel_data;

    // Pick the byte at the current position.
    always_comb begin
        case (idx_reg)
            2'd0:    sel_data = data_reg[0];
            2'd1:    sel_data = data_reg[1];
            2'd2:    sel_data = data_reg[2];
            default: sel_data = 8'h00;
        endcase
    end

    // Current result: leading marker, then bytes, then trailing marker.
    always_comb begin
        if (pre_reg) begin
            m_out_byte   = 8'h00;
            m_byte_valid = 1'b0;
            m_token_end  = 1'b1;
            last         = (left_reg == 2'd0) && !post_reg;
        end else if (left_reg != 2'd0) begin
            m_out_byte   = sel_data;
            m_byte_valid = 1'b1;
            m_token_end  = 1'b0;
            last         = (left_reg == 2'd1) && !post_reg;
        end else begin
            m_out_byte   = 8'h00;
            m_byte_valid = 1'b0;
            m_token_end  = 1'b1;
            last         = 1'b1;
        end
    end

    assign m_valid    = valid_reg;
    assign m_run_last = last;
    assign xfer       = valid_reg && m_ready;
    assign pop        = (!valid_reg || (xfer && last)) && !status.empty;

    // Bundle register and position within it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            pre_reg   <= 1'b0;
            post_reg  <= 1'b0;
            left_reg  <= 2'd0;
            idx_reg   <= 2'd0;
        end else if (pop) begin
            valid_reg <= 1'b1;
            pre_reg   <= pop_data.pre_end;
            post_reg  <= pop_data.post_end;
            left_reg  <= pop_data.nbytes;
            idx_reg   <= 2'd0;
        end else if (xfer) begin
            if (last) begin
                valid_reg <= 1'b0;
            end else if (pre_reg) begin
                pre_reg <= 1'b0;
            end else if (left_reg != 2'd0) begin
                left_reg <= left_reg - 2'd1;
                idx_reg  <= idx_reg + 2'd1;
            end else begin
                post_reg <= 1'b0;
            end
        end
    end

    // Byte payload needs no reset.
    always_ff @(posedge aclk) begin
        if (pop) begin
            data_reg <= pop_data.data;
        end
    end

endmodule

@@ sv/utf8_token_splitter_case_fold.sv @@
// Path: an accepted byte's bundle is written into the queue, then popped into the
// output bundle register, from which its first result is offered.
// Throughput: one input byte per cycle while the queue has room, which holds
// while each byte yields at most one result; the output sends one result per
// cycle while m_ready is high, and a four-entry bundle queue absorbs bursts.
// Reset: synchronous, active low; clears decoder state, queue and output stage.
module utf8_token_splitter_case_fold (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] s_in_byte,
    input  logic       s_text_end,
    input  logic       s_valid,
    output logic       s_ready,
    output logic [7:0] m_out_byte,
    output logic       m_byte_valid,
    output logic       m_token_end,
    output logic       m_run_last,
    output logic       m_valid,
    input  logic       m_ready
);
    import utsc_pkg::*;

    logic      push;
    logic      pop;
    bundle_t   push_data;
    bundle_t   pop_data;
    q_status_t status;

    // Input transfers are taken whenever the queue has room.
    assign s_ready = !status.full;

    utsc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_take   (s_valid && s_ready),
        .in_data   (s_in_byte),
        .in_end    (s_text_end),
        .push      (push),
        .push_data (push_data)
    );

    utsc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (status)
    );

    utsc_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .pop_data     (pop_data),
        .status       (status),
        .pop          (pop),
        .m_out_byte   (m_out_byte),
        .m_byte_valid (m_byte_valid),
        .m_token_end  (m_token_end),
        .m_run_last   (m_run_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready)
    );

endmodule

@@ sv/utsc_checker.sv @@
// Port-level checks for the UTF-8 token splitter, bound to the top level.
// Depends only on the top-level ports.
module utsc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic [7:0] m_out_byte,
    input logic       m_byte_valid,
    input logic       m_token_end,
    input logic       m_run_last,
    input logic       m_valid,
    input logic       m_ready
);

    // The output stage comes out of reset empty.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result offered right after reset");

    // A stalled result holds.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_token_end))
        else $error("stalled result changed");

    // A token byte never carries an end marker.
    a_byte_no_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_byte_valid |-> !m_token_end)
        else $error("token byte flagged as token end");

    // A pure marker is always a zero-byte token end.
    a_marker_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_byte_valid |-> m_token_end && (m_out_byte == 8'h00))
        else $error("malformed marker result");

    // A marker that does not close its run is followed at once by token bytes.
    a_marker_then_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_token_end && !m_run_last |=> m_valid && m_byte_valid)
        else $error("leading marker not followed by token bytes");

endmodule

bind utf8_token_splitter_case_fold utsc_checker u_utsc_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_out_byte   (m_out_byte),
    .m_byte_valid (m_byte_valid),
    .m_token_end  (m_token_end),
    .m_run_last   (m_run_last),
    .m_valid      (m_valid),
    .m_ready      (m_ready)
);
